@@ design/sbhs_pkg.sv @@
// Package for the seed-byte generator: constants, register indexes, the
// controller state type and the command and status bundles between the
// controller and the datapath. Depends on nothing.
`default_nettype none

package sbhs_pkg;

	// Configuration port.
	localparam int unsigned CFG_IDX_W  = 2;
	localparam int unsigned CFG_DATA_W = 64;
	localparam logic [CFG_IDX_W-1:0] REG_OUT_BYTES  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_HASH_BASIS = 2'd1;

	// Field widths.
	localparam int unsigned OUT_BYTES_W = 7;
	localparam int unsigned WORD_W      = 64;
	localparam int unsigned VBYTES_W    = 4;
	localparam int unsigned HALF_W      = 32;

	// Default for the top-level parameter.
	localparam int unsigned MAX_OUT_BYTES_DEF = 64;

	// Reset values of the registers.
	localparam logic [OUT_BYTES_W-1:0] OUT_BYTES_RST = 7'd64;
	localparam logic [WORD_W-1:0]      FNV_BASIS     = 64'hcbf2_9ce4_8422_2325;

	// Hash and mixer constants.
	localparam logic [WORD_W-1:0] GOLDEN    = 64'h9e37_79b9_7f4a_7c15;
	localparam logic [WORD_W-1:0] MIX_MUL_A = 64'hbf58_476d_1ce4_e5b9;
	localparam logic [WORD_W-1:0] MIX_MUL_B = 64'h94d0_49bb_1331_11eb;

	// Controller states.
	typedef enum logic [3:0] {
		ST_IDLE,
		ST_COMB_A,
		ST_COMB_B,
		ST_GEN,
		ST_MA0,
		ST_MA1,
		ST_MA2,
		ST_MA3,
		ST_MIX,
		ST_MB0,
		ST_MB1,
		ST_MB2,
		ST_MB3,
		ST_FIN
	} state_t;

	// Datapath operation codes.
	typedef enum logic [1:0] {
		Z_HOLD,
		Z_COMB,
		Z_GEN,
		Z_MIX
	} z_op_t;

	typedef enum logic [1:0] {
		GEN_HOLD,
		GEN_COMB,
		GEN_STEP
	} gen_op_t;

	typedef enum logic [1:0] {
		PP_LL,
		PP_LH,
		PP_HL
	} pp_sel_t;

	typedef enum logic [1:0] {
		ACC_HOLD,
		ACC_LOAD,
		ACC_ADD_HI
	} acc_op_t;

	typedef struct packed {
		logic    hash_seed;
		logic    hash_dom;
		z_op_t   z_op;
		gen_op_t gen_op;
		pp_sel_t pp_sel;
		logic    const_b;
		acc_op_t acc_op;
		logic    out_load;
	} dp_cmd_t;

	typedef struct packed {
		logic total_zero;
		logic last_chunk;
		logic out_free;
	} dp_status_t;

endpackage

`default_nettype wire

@@ design/sbhs_ctrl.sv @@
// Controller of the seed-byte generator: sequences hashing, the combine
// step and the word loop of the datapath. Depends on sbhs_pkg.
`default_nettype none

module sbhs_ctrl
	import sbhs_pkg::*;
(
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       in_valid,
	output logic            in_ready,
	input  wire logic       has_byte,
	input  wire logic       source,
	input  wire logic       end_of_string,
	output dp_cmd_t         cmd,
	input  wire dp_status_t status
);

	state_t state_q;
	state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Next state.
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid && source && end_of_string) begin
					state_d = ST_COMB_A;
				end
			end
			ST_COMB_A: state_d = ST_COMB_B;
			ST_COMB_B: state_d = status.total_zero ? ST_IDLE : ST_GEN;
			ST_GEN:    state_d = ST_MA0;
			ST_MA0:    state_d = ST_MA1;
			ST_MA1:    state_d = ST_MA2;
			ST_MA2:    state_d = ST_MA3;
			ST_MA3:    state_d = ST_MIX;
			ST_MIX:    state_d = ST_MB0;
			ST_MB0:    state_d = ST_MB1;
			ST_MB1:    state_d = ST_MB2;
			ST_MB2:    state_d = ST_MB3;
			ST_MB3:    state_d = ST_FIN;
			ST_FIN: begin
				if (status.out_free) begin
					state_d = status.last_chunk ? ST_IDLE : ST_GEN;
				end
			end
			default:   state_d = ST_IDLE;
		endcase
	end

	// Outputs.
	always_comb begin
		in_ready      = 1'b0;
		cmd.hash_seed = 1'b0;
		cmd.hash_dom  = 1'b0;
		cmd.z_op      = Z_HOLD;
		cmd.gen_op    = GEN_HOLD;
		cmd.pp_sel    = PP_LL;
		cmd.const_b   = 1'b0;
		cmd.acc_op    = ACC_HOLD;
		cmd.out_load  = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				in_ready      = 1'b1;
				cmd.hash_seed = in_valid && !source && has_byte;
				cmd.hash_dom  = in_valid && source && has_byte;
			end
			ST_COMB_A: cmd.z_op = Z_COMB;
			ST_COMB_B: cmd.gen_op = GEN_COMB;
			ST_GEN: begin
				cmd.gen_op = GEN_STEP;
				cmd.z_op   = Z_GEN;
			end
			ST_MA0: cmd.pp_sel = PP_LL;
			ST_MA1: begin
				cmd.pp_sel = PP_LH;
				cmd.acc_op = ACC_LOAD;
			end
			ST_MA2: begin
				cmd.pp_sel = PP_HL;
				cmd.acc_op = ACC_ADD_HI;
			end
			ST_MA3: cmd.acc_op = ACC_ADD_HI;
			ST_MIX: cmd.z_op = Z_MIX;
			ST_MB0: begin
				cmd.pp_sel  = PP_LL;
				cmd.const_b = 1'b1;
			end
			ST_MB1: begin
				cmd.pp_sel  = PP_LH;
				cmd.const_b = 1'b1;
				cmd.acc_op  = ACC_LOAD;
			end
			ST_MB2: begin
				cmd.pp_sel  = PP_HL;
				cmd.const_b = 1'b1;
				cmd.acc_op  = ACC_ADD_HI;
			end
			ST_MB3: cmd.acc_op = ACC_ADD_HI;
			ST_FIN: cmd.out_load = status.out_free;
			default: begin
			end
		endcase
	end

endmodule

`default_nettype wire

@@ design/sbhs_dp.sv @@
// Datapath of the seed-byte generator: configuration registers, the two
// FNV-1a hashes, the mixer state with a shared 32x32 multiplier, the byte
// counters and the output register. Depends on sbhs_pkg.
`default_nettype none

module sbhs_dp
	import sbhs_pkg::*;
#(
	parameter int unsigned MAX_OUT_BYTES = MAX_OUT_BYTES_DEF
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  cfg_we,
	input  wire logic [CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [CFG_DATA_W-1:0] cfg_data,
	input  wire logic [7:0]            data_byte,
	input  wire dp_cmd_t               cmd,
	output dp_status_t                 status,
	output logic                       out_valid,
	input  wire logic                  out_ready,
	output logic [WORD_W-1:0]          seed_word,
	output logic [VBYTES_W-1:0]        valid_bytes,
	output logic                       last_word
);

	// Multiply by the FNV prime 2^40 + 0x1b3 as a sum of shifts.
	function automatic logic [WORD_W-1:0] fnv_step(input logic [WORD_W-1:0] h,
		input logic [7:0] b);
		logic [WORD_W-1:0] x;
		x = h ^ {56'd0, b};
		return (x << 40) + (x << 8) + (x << 7) + (x << 5) + (x << 4) + (x << 1) + x;
	endfunction

	logic [OUT_BYTES_W-1:0] out_bytes_q;
	logic [WORD_W-1:0]      basis_q;
	logic [WORD_W-1:0]      seed_hash_q;
	logic [WORD_W-1:0]      dom_hash_q;
	logic [WORD_W-1:0]      gen_q;
	logic [WORD_W-1:0]      z_q;
	logic [WORD_W-1:0]      p_q;
	logic [WORD_W-1:0]      acc_q;
	logic [OUT_BYTES_W-1:0] total_q;
	logic [OUT_BYTES_W-1:0] done_q;
	logic                   out_valid_q;
	logic [WORD_W-1:0]      word_q;
	logic [VBYTES_W-1:0]    vbytes_q;
	logic                   last_q;

	logic [WORD_W-1:0]      gen_next;
	logic [HALF_W-1:0]      mul_a;
	logic [HALF_W-1:0]      mul_b;
	logic [WORD_W-1:0]      mul_c;
	logic [WORD_W-1:0]      p_d;
	logic [OUT_BYTES_W-1:0] total_sat;
	logic [OUT_BYTES_W-1:0] rem;
	logic [VBYTES_W-1:0]    chunk;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_bytes_q <= OUT_BYTES_RST;
			basis_q     <= FNV_BASIS;
		end else if (cfg_we) begin
			if (cfg_index == REG_OUT_BYTES) begin
				out_bytes_q <= cfg_data[OUT_BYTES_W-1:0];
			end else if (cfg_index == REG_HASH_BASIS) begin
				basis_q <= cfg_data;
			end
		end
	end

	always_comb begin
		if (32'(out_bytes_q) > 32'(MAX_OUT_BYTES)) begin
			total_sat = OUT_BYTES_W'(MAX_OUT_BYTES);
		end else begin
			total_sat = out_bytes_q;
		end
	end

	// String hashes; both return to the basis once a run is set up.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seed_hash_q <= FNV_BASIS;
			dom_hash_q  <= FNV_BASIS;
		end else if (cmd.gen_op == GEN_COMB) begin
			seed_hash_q <= basis_q;
			dom_hash_q  <= basis_q;
		end else begin
			if (cmd.hash_seed) begin
				seed_hash_q <= fnv_step(seed_hash_q, data_byte);
			end
			if (cmd.hash_dom) begin
				dom_hash_q <= fnv_step(dom_hash_q, data_byte);
			end
		end
	end

	assign gen_next = gen_q + GOLDEN;

	always_ff @(posedge clk) begin
		unique case (cmd.gen_op)
			GEN_COMB: gen_q <= seed_hash_q ^ (z_q + (seed_hash_q << 6) + (seed_hash_q >> 2));
			GEN_STEP: gen_q <= gen_next;
			default:  gen_q <= gen_q;
		endcase
		unique case (cmd.z_op)
			Z_COMB:  z_q <= dom_hash_q + GOLDEN;
			Z_GEN:   z_q <= gen_next ^ (gen_next >> 30);
			Z_MIX:   z_q <= acc_q ^ (acc_q >> 27);
			default: z_q <= z_q;
		endcase
	end

	// Shared multiplier: three partial products give the low 64 bits.
	assign mul_c = cmd.const_b ? MIX_MUL_B : MIX_MUL_A;

	always_comb begin
		unique case (cmd.pp_sel)
			PP_LH: begin
				mul_a = z_q[HALF_W-1:0];
				mul_b = mul_c[WORD_W-1:HALF_W];
			end
			PP_HL: begin
				mul_a = z_q[WORD_W-1:HALF_W];
				mul_b = mul_c[HALF_W-1:0];
			end
			default: begin
				mul_a = z_q[HALF_W-1:0];
				mul_b = mul_c[HALF_W-1:0];
			end
		endcase
	end

	assign p_d = mul_a * mul_b;

	always_ff @(posedge clk) begin
		p_q <= p_d;
		unique case (cmd.acc_op)
			ACC_LOAD:   acc_q <= p_q;
			ACC_ADD_HI: acc_q <= acc_q + {p_q[HALF_W-1:0], {HALF_W{1'b0}}};
			default:    acc_q <= acc_q;
		endcase
	end

	// Byte accounting for the run.
	assign rem   = total_q - done_q;
	assign chunk = (rem > OUT_BYTES_W'(8)) ? VBYTES_W'(8) : rem[VBYTES_W-1:0];

	always_ff @(posedge clk) begin
		if (cmd.gen_op == GEN_COMB) begin
			total_q <= total_sat;
			done_q  <= '0;
		end else if (cmd.out_load) begin
			done_q <= done_q + OUT_BYTES_W'(chunk);
		end
	end

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.out_load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			word_q   <= acc_q ^ (acc_q >> 31);
			vbytes_q <= chunk;
			last_q   <= (rem <= OUT_BYTES_W'(8));
		end
	end

	assign status.total_zero = (total_sat == '0);
	assign status.last_chunk = (rem <= OUT_BYTES_W'(8));
	assign status.out_free   = !out_valid_q || out_ready;

	assign out_valid   = out_valid_q;
	assign seed_word   = word_q;
	assign valid_bytes = vbytes_q;
	assign last_word   = last_q;

endmodule

`default_nettype wire

@@ design/seed_bytes_from_hashed_strings.sv @@
// Top level of the seed-byte generator: joins the controller and the datapath.
// Depends on sbhs_pkg, sbhs_ctrl and sbhs_dp.
//
// A seed string (source 0) and a domain string (source 1) stream in one byte
// per transfer, and each is hashed with 64-bit FNV-1a starting from the
// hash_basis register. The item that ends the domain string starts a run that
// combines the two hashes, returns both hashes to the basis and emits
// SplitMix64 words until out_bytes bytes (at most MAX_OUT_BYTES) are covered,
// with words little-endian and the last one carrying a partial count in
// valid_bytes. The run has a setup and then takes one word after another:
// each word goes through two 64-bit multiplications, each formed from three
// partial products on one shared 32x32 multiplier, and a stall on the output
// side holds the run. No input transfer is taken during a run, but the block
// takes input again while its final word still waits in the output register.
// With out_bytes at zero the run emits no word and ends after its setup.
// Configuration must be written only while no run is in progress; the block
// itself does not enforce it. A write to an unknown index is ignored, and a
// new hash_basis takes effect at the next return to the basis.
`default_nettype none

module seed_bytes_from_hashed_strings
	import sbhs_pkg::*;
#(
	parameter int unsigned MAX_OUT_BYTES = MAX_OUT_BYTES_DEF
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  cfg_we,
	input  wire logic [CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [CFG_DATA_W-1:0] cfg_data,
	input  wire logic                  in_valid,
	output logic                       in_ready,
	input  wire logic [7:0]            data_byte,
	input  wire logic                  has_byte,
	input  wire logic                  source,
	input  wire logic                  end_of_string,
	output logic                       out_valid,
	input  wire logic                  out_ready,
	output logic [WORD_W-1:0]          seed_word,
	output logic [VBYTES_W-1:0]        valid_bytes,
	output logic                       last_word
);

	// Commands from the controller and status back from the datapath.
	dp_cmd_t    cmd;
	dp_status_t status;

	sbhs_ctrl u_ctrl (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_ready      (in_ready),
		.has_byte      (has_byte),
		.source        (source),
		.end_of_string (end_of_string),
		.cmd           (cmd),
		.status        (status)
	);

	sbhs_dp #(
		.MAX_OUT_BYTES (MAX_OUT_BYTES)
	) u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_we      (cfg_we),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.data_byte   (data_byte),
		.cmd         (cmd),
		.status      (status),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.seed_word   (seed_word),
		.valid_bytes (valid_bytes),
		.last_word   (last_word)
	);

endmodule

`default_nettype wire

@@ tb/seed_bytes_checker.sv @@
`timescale 1ns / 100ps
// Checker for the seed-byte generator: it follows the configuration port and both transfer
// channels, predicts every output word and compares the words as they arrive.
// Depends on sbhs_pkg for the widths, the register indexes and the mixer constants.
module seed_bytes_checker
	import sbhs_pkg::*;
#(
	parameter int unsigned MAX_OUT_BYTES = MAX_OUT_BYTES_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	input  logic                  in_valid,
	input  logic                  in_ready,
	input  logic [7:0]            data_byte,
	input  logic                  has_byte,
	input  logic                  source,
	input  logic                  end_of_string,
	input  logic                  out_valid,
	input  logic                  out_ready,
	input  logic [WORD_W-1:0]     seed_word,
	input  logic [VBYTES_W-1:0]   valid_bytes,
	input  logic                  last_word,
	output int                    mismatch_count,
	output int                    owed_count,
	output int                    words_checked
);

	localparam logic [WORD_W-1:0] FNV_PRIME = 64'h0000_0100_0000_01b3;

	typedef struct packed {
		logic [WORD_W-1:0]   word;
		logic [VBYTES_W-1:0] nbytes;
		logic                last;
	} seed_word_t;

	seed_word_t owed_words[$];

	// Shadow copies of the registers and of both running hashes.
	logic [OUT_BYTES_W-1:0] out_bytes_m;
	logic [WORD_W-1:0]      basis_m;
	logic [WORD_W-1:0]      seed_hash_m;
	logic [WORD_W-1:0]      domain_hash_m;

	function automatic logic [WORD_W-1:0] fnv1a_absorb(input logic [WORD_W-1:0] h,
		input logic [7:0] b);
		return (h ^ {56'd0, b}) * FNV_PRIME;
	endfunction

	function automatic logic [WORD_W-1:0] splitmix_scramble(input logic [WORD_W-1:0] g);
		logic [WORD_W-1:0] z;
		z = (g ^ (g >> 30)) * MIX_MUL_A;
		z = (z ^ (z >> 27)) * MIX_MUL_B;
		return z ^ (z >> 31);
	endfunction

	// Applies one input transfer; a domain end queues the whole run of words.
	task automatic hash_or_expand(input logic [7:0] b, input logic has, input logic src,
		input logic eos);
		logic [WORD_W-1:0] gen_state;
		int unsigned total;
		int unsigned done;
		int unsigned chunk;
		seed_word_t w;
		if (!src) begin
			if (has) seed_hash_m = fnv1a_absorb(seed_hash_m, b);
		end else begin
			if (has) domain_hash_m = fnv1a_absorb(domain_hash_m, b);
			if (eos) begin
				gen_state = seed_hash_m ^ (domain_hash_m + GOLDEN + (seed_hash_m << 6)
					+ (seed_hash_m >> 2));
				total = (out_bytes_m > MAX_OUT_BYTES) ? MAX_OUT_BYTES : out_bytes_m;
				done = 0;
				while (done < total) begin
					gen_state = gen_state + GOLDEN;
					chunk = (total - done > 8) ? 8 : total - done;
					done += chunk;
					w.word = splitmix_scramble(gen_state);
					w.nbytes = VBYTES_W'(chunk);
					w.last = (done >= total);
					owed_words.insert(owed_words.size(), w);
				end
				seed_hash_m = basis_m;
				domain_hash_m = basis_m;
			end
		end
	endtask

	task automatic check_word();
		seed_word_t want;
		if (owed_words.size() == 0) begin
			mismatch_count++;
			if (mismatch_count <= 10)
				$display("%0t: unexpected word %h bytes=%0d last=%0b", $realtime,
					seed_word, valid_bytes, last_word);
		end else begin
			want = owed_words.pop_front();
			words_checked++;
			if (seed_word !== want.word || valid_bytes !== want.nbytes
				|| last_word !== want.last) begin
				mismatch_count++;
				if (mismatch_count <= 10)
					$display("%0t: word %0d expected %h/%0d/%0b, got %h/%0d/%0b",
						$realtime, words_checked, want.word, want.nbytes, want.last,
						seed_word, valid_bytes, last_word);
			end
		end
	endtask

	initial begin
		mismatch_count = 0;
		words_checked = 0;
		owed_count = 0;
	end

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_bytes_m = OUT_BYTES_RST;
			basis_m = FNV_BASIS;
			seed_hash_m = FNV_BASIS;
			domain_hash_m = FNV_BASIS;
			owed_words.delete();
			owed_count = 0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
				REG_OUT_BYTES:  out_bytes_m = cfg_data[OUT_BYTES_W-1:0];
				REG_HASH_BASIS: basis_m = cfg_data;
				default: ;
				endcase
			end
			if (out_valid && out_ready) check_word();
			if (in_valid && in_ready)
				hash_or_expand(data_byte, has_byte, source, end_of_string);
			owed_count = owed_words.size();
		end
	end

endmodule

@@ tb/seed_bytes_from_hashed_strings_tb.sv @@
`timescale 1ns / 100ps
// Top of the seed-byte generator testbench: clock, reset, stimulus, receiver pacing and
// the verdict. Depends on sbhs_pkg, the block seed_bytes_from_hashed_strings and the
// checker module seed_bytes_checker.
module seed_bytes_from_hashed_strings_tb
	import sbhs_pkg::*;
();

	localparam int unsigned MAX_BYTES     = MAX_OUT_BYTES_DEF;
	localparam int          RANDOM_ITEMS  = 245;
	localparam int          CYCLE_LIMIT   = 200000;
	// The block may still be finishing a run that emits no word (still in its setup)
	// when the last owed word has been taken, so a quiet stretch precedes every write.
	localparam int          SETTLE_CYCLES = 16;
	localparam int          LONG_HOLD     = 400;

	localparam logic SRC_SEED   = 1'b0;
	localparam logic SRC_DOMAIN = 1'b1;

	// Indexes that name no register; writes to them must change nothing.
	localparam logic [CFG_IDX_W-1:0] REG_SPARE_2 = 2'd2;
	localparam logic [CFG_IDX_W-1:0] REG_SPARE_3 = 2'd3;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0]  cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;
	logic                  in_valid = 1'b0;
	logic                  in_ready;
	logic [7:0]            data_byte = '0;
	logic                  has_byte = 1'b0;
	logic                  source = 1'b0;
	logic                  end_of_string = 1'b0;
	logic                  out_valid;
	logic                  out_ready = 1'b0;
	logic [WORD_W-1:0]     seed_word;
	logic [VBYTES_W-1:0]   valid_bytes;
	logic                  last_word;

	int mismatch_total;
	int words_owed;
	int words_checked;

	int cycle_count = 0;
	int items_sent = 0;
	int directed_count = 0;
	int phase_count = 0;
	int burst_left = 0;
	bit sender_gaps = 1'b0;
	// Raised by the stimulus, taken and cleared by the receiver process.
	bit long_hold_req = 1'b0;

	seed_bytes_from_hashed_strings #(
		.MAX_OUT_BYTES(MAX_BYTES)
	) DUT (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.data_byte(data_byte),
		.has_byte(has_byte),
		.source(source),
		.end_of_string(end_of_string),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.seed_word(seed_word),
		.valid_bytes(valid_bytes),
		.last_word(last_word)
	);

	seed_bytes_checker #(
		.MAX_OUT_BYTES(MAX_BYTES)
	) word_check (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.data_byte(data_byte),
		.has_byte(has_byte),
		.source(source),
		.end_of_string(end_of_string),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.seed_word(seed_word),
		.valid_bytes(valid_bytes),
		.last_word(last_word),
		.mismatch_count(mismatch_total),
		.owed_count(words_owed),
		.words_checked(words_checked)
	);

	always #10 clk = ~clk;

	// Watchdog: a hung handshake or a word that never comes ends the run here.
	initial begin : watchdog
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("Timeout after %0d cycles with %0d words still owed.", cycle_count,
			words_owed);
		$display("[seed_bytes_from_hashed_strings] ERROR");
		$finish;
	end

	// Receiver pacing. It switches at random between patterns: always ready, mostly
	// ready, mostly stalled and alternating. On request it holds off for a long
	// stretch, counted here, so that the output register stays full, the run stalls
	// and the block stops taking input while the sender keeps offering.
	initial begin : receiver
		int hold_left;
		int mode_left;
		int mode;
		hold_left = 0;
		mode_left = 0;
		mode = 0;
		forever begin
			@(negedge clk);
			if (long_hold_req) begin
				hold_left = LONG_HOLD;
				long_hold_req = 1'b0;
			end
			if (hold_left > 0) begin
				hold_left--;
				out_ready <= 1'b0;
			end else begin
				if (mode_left == 0) begin
					mode = $urandom_range(0, 3);
					mode_left = $urandom_range(20, 120);
				end
				mode_left--;
				case (mode)
				0: out_ready <= 1'b1;
				1: out_ready <= ($urandom_range(0, 3) != 0);
				2: out_ready <= ($urandom_range(0, 3) == 0);
				default: out_ready <= ~out_ready;
				endcase
			end
		end
	end

	// Configuration writes happen only while the block is idle.
	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] value);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	// Lowers valid and waits out a pause whose length n sets.
	task automatic pause_sender(input int n);
		@(negedge clk);
		in_valid <= 1'b0;
		repeat (n - 1) @(negedge clk);
	endtask

	// Presents one item and holds it until the transfer happens. The payload changes
	// only at a falling edge, and ready is read right at the rising edge, before the
	// block's registers update.
	task automatic drive_transfer(input logic [7:0] b, input logic has, input logic src,
		input logic eos);
		@(negedge clk);
		in_valid <= 1'b1;
		data_byte <= b;
		has_byte <= has;
		source <= src;
		end_of_string <= eos;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
	endtask

	// One item, with burst pacing: when gaps are on, a random gap separates bursts of
	// random length; with gaps off the items go back to back.
	task automatic offer(input logic [7:0] b, input logic has, input logic src, input logic eos);
		if (sender_gaps && burst_left == 0) begin
			pause_sender($urandom_range(1, 8));
			burst_left = $urandom_range(1, 12);
		end
		drive_transfer(b, has, src, eos);
		if (burst_left > 0) burst_left--;
		items_sent++;
	endtask

	// A string of len bytes ending on its end marker. An empty string is a lone end
	// marker without a byte. Holes are items without a byte inside the string; their
	// data must be ignored.
	task automatic send_string(input logic src, input int len, input bit holes);
		if (len == 0) offer(8'($urandom), 1'b0, src, 1'b1);
		for (int i = 0; i < len; i++) begin
			if (holes && $urandom_range(0, 3) == 0) offer(8'($urandom), 1'b0, src, 1'b0);
			offer(8'($urandom), 1'b1, src, i == len - 1);
		end
	endtask

	task automatic send_pair(input int seed_len, input int dom_len, input bit holes);
		send_string(SRC_SEED, seed_len, holes);
		send_string(SRC_DOMAIN, dom_len, holes);
	endtask

	// Fully random items: strings interleaved, end markers anywhere.
	task automatic send_noise(input int n);
		repeat (n)
			offer(8'($urandom), 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
				$urandom_range(0, 3) == 0);
	endtask

	// Stops offering and waits until every owed word has been taken, then lets the
	// block settle.
	task automatic drain_results();
		@(negedge clk);
		in_valid <= 1'b0;
		while (words_owed != 0) @(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	initial begin : stimulus
		int unsigned obytes;
		int unsigned kind;
		int phase_target;

		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Directed part. First the reset values: default basis and a full 64-byte run,
		// with the extreme byte values.
		offer(8'h00, 1'b1, SRC_SEED, 1'b0);
		offer(8'hff, 1'b1, SRC_SEED, 1'b1);
		offer(8'h7f, 1'b1, SRC_DOMAIN, 1'b1);
		// Two empty strings: both hashes stay at the basis. The data bytes are noise.
		offer(8'h5a, 1'b0, SRC_SEED, 1'b1);
		offer(8'ha5, 1'b0, SRC_DOMAIN, 1'b1);

		// Zero length with a zero basis: the domain end emits nothing, yet the hashes
		// still return to the basis.
		drain_results();
		write_reg(REG_OUT_BYTES, CFG_DATA_W'(0));
		write_reg(REG_HASH_BASIS, '0);
		offer(8'h01, 1'b1, SRC_SEED, 1'b1);
		offer(8'h80, 1'b1, SRC_DOMAIN, 1'b1);

		// A single byte: one partial word.
		drain_results();
		write_reg(REG_OUT_BYTES, CFG_DATA_W'(1));
		offer(8'h55, 1'b1, SRC_SEED, 1'b1);
		offer(8'haa, 1'b1, SRC_DOMAIN, 1'b1);

		// Nine bytes from the earlier zero basis: a full word and then a one-byte word.
		drain_results();
		write_reg(REG_OUT_BYTES, CFG_DATA_W'(9));
		write_reg(REG_HASH_BASIS, '1);
		send_pair(1, 1, 1'b0);

		// The largest count saturates to the maximum.
		drain_results();
		write_reg(REG_OUT_BYTES, CFG_DATA_W'(127));
		send_pair(0, 1, 1'b0);

		// A basis write while the seed hash is in progress leaves that hash alone; the
		// new basis shows only after the run.
		drain_results();
		write_reg(REG_OUT_BYTES, CFG_DATA_W'(16));
		offer(8'h3c, 1'b1, SRC_SEED, 1'b0);
		offer(8'hc3, 1'b1, SRC_SEED, 1'b0);
		drain_results();
		write_reg(REG_HASH_BASIS, {$urandom, $urandom});
		offer(8'h10, 1'b1, SRC_DOMAIN, 1'b1);
		send_pair(1, 1, 1'b0);

		// Writes to indexes that name no register, then interleaved strings: a domain
		// byte before the seed ends, a repeated seed end marker and seed bytes after the
		// seed end all keep accumulating.
		drain_results();
		write_reg(REG_SPARE_2, '1);
		write_reg(REG_SPARE_3, {$urandom, $urandom});
		offer(8'h21, 1'b1, SRC_DOMAIN, 1'b0);
		offer(8'h42, 1'b1, SRC_SEED, 1'b0);
		offer(8'h84, 1'b1, SRC_SEED, 1'b1);
		offer(8'h18, 1'b1, SRC_SEED, 1'b0);
		offer(8'h99, 1'b0, SRC_SEED, 1'b1);
		offer(8'he7, 1'b1, SRC_DOMAIN, 1'b1);
		directed_count = items_sent;

		// Random part, in phases. Each phase starts from an idle block (the sender
		// waits for every owed word), writes a fresh setting and then streams mostly
		// well-formed pairs with random content, some with holes, some seed strings
		// left open and some pure noise.
		while (items_sent - directed_count < RANDOM_ITEMS) begin
			drain_results();
			phase_count++;
			case ($urandom_range(0, 7))
			0: obytes = 0;
			1: obytes = $urandom_range(65, 127);
			2: obytes = MAX_BYTES;
			3: obytes = 1;
			default: obytes = $urandom_range(2, 63);
			endcase
			write_reg(REG_OUT_BYTES, CFG_DATA_W'(obytes));
			case ($urandom_range(0, 4))
			0: write_reg(REG_HASH_BASIS, {$urandom, $urandom});
			1: write_reg(REG_HASH_BASIS, FNV_BASIS);
			2: write_reg(REG_SPARE_2, {$urandom, $urandom});
			default: ;
			endcase
			sender_gaps = ($urandom_range(0, 3) != 0);
			burst_left = 0;
			// In the second phase the receiver holds off for a long stretch while the
			// sender keeps offering back to back.
			if (phase_count == 2) begin
				if (obytes == 0) write_reg(REG_OUT_BYTES, CFG_DATA_W'(MAX_BYTES));
				sender_gaps = 1'b0;
				long_hold_req = 1'b1;
			end
			phase_target = items_sent + $urandom_range(25, 50);
			while (items_sent < phase_target
				&& items_sent - directed_count < RANDOM_ITEMS) begin
				kind = $urandom_range(0, 9);
				if (kind <= 5) send_pair($urandom_range(0, 4), $urandom_range(0, 4), 1'b0);
				else if (kind == 6)
					send_pair($urandom_range(5, 16), $urandom_range(0, 12), 1'b1);
				else if (kind == 7) send_string(SRC_SEED, $urandom_range(1, 6), 1'b1);
				else send_noise($urandom_range(1, 6));
			end
		end

		drain_results();
		$display("Run covered %0d input transfers (%0d directed) over %0d random phases.",
			items_sent, directed_count, phase_count);
		$display("Compared %0d seed words; %0d mismatches.", words_checked, mismatch_total);
		if (mismatch_total == 0 && words_owed == 0) begin
			$display("[seed_bytes_from_hashed_strings] OK");
		end else begin
			$display("[seed_bytes_from_hashed_strings] ERROR");
		end
		$finish;
	end

endmodule
